// ===== hw/rtl/transport_switch_mute_guard_unit_assert.svh =====
// Assertion macros used by the mute guard checker.
`ifndef TRANSPORT_SWITCH_MUTE_GUARD_UNIT_ASSERT_SVH
`define TRANSPORT_SWITCH_MUTE_GUARD_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TSMG_ASSERT_NOW(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("mute guard check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TSMG_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("mute guard check failed");

`endif

// ===== hw/rtl/tsmg_pkg.sv =====
// Shared codes and constants of the transport switch mute guard.
`default_nettype none

package tsmg_pkg;

	// Clamp applied to frame counts and register writes
	localparam int unsigned MAX_FRAMES_DEFAULT = 65535;

	// Item modes
	localparam logic [1:0] MODE_CALLBACK = 2'd0;
	localparam logic [1:0] MODE_ARM      = 2'd1;
	localparam logic [1:0] MODE_LOCK     = 2'd2;
	localparam logic [1:0] MODE_STOP     = 2'd3;

	// Transport codes
	localparam logic [1:0] TR_PCM    = 2'd0;
	localparam logic [1:0] TR_DOP    = 2'd1;
	localparam logic [1:0] TR_NATIVE = 2'd2;

	// Guard state codes as shown on guard_state
	localparam logic [2:0] GS_STOPPED  = 3'd0;
	localparam logic [2:0] GS_LOCKING  = 3'd1;
	localparam logic [2:0] GS_MUTING   = 3'd2;
	localparam logic [2:0] GS_READY    = 3'd3;
	localparam logic [2:0] GS_FALLBACK = 3'd4;

	// Switch kinds
	localparam logic [2:0] SK_NONE       = 3'd0;
	localparam logic [2:0] SK_PCM_DOP    = 3'd1;
	localparam logic [2:0] SK_DOP_PCM    = 3'd2;
	localparam logic [2:0] SK_PCM_NATIVE = 3'd3;
	localparam logic [2:0] SK_NATIVE_PCM = 3'd4;
	localparam logic [2:0] SK_DOP_NATIVE = 3'd5;
	localparam logic [2:0] SK_NATIVE_DOP = 3'd6;
	localparam logic [2:0] SK_RATE       = 3'd7;

	// Silence fill bytes
	localparam logic [7:0] FILL_PCM    = 8'h00;
	localparam logic [7:0] FILL_DOP    = 8'h96;
	localparam logic [7:0] FILL_NATIVE = 8'h69;

	// Register indexes
	localparam logic [1:0] REG_PRE_ROLL  = 2'd0;
	localparam logic [1:0] REG_POST_ROLL = 2'd1;
	localparam logic [1:0] REG_TIMEOUT   = 2'd2;

	// Lock timeout used at reset and for a written zero
	localparam logic [15:0] TIMEOUT_DEFAULT = 16'd4096;

	// Saturation value of the lock wait counter
	localparam logic [16:0] WAIT_MAX = 17'h1FFFF;

endpackage

`default_nettype wire

// ===== hw/rtl/transport_switch_mute_guard_unit.sv =====
// Top level of the transport switch mute guard.
//
// Input channel (in_valid/in_ready) takes one item per transfer: mode selects
// audio callback, arm switch, confirm lock or stop; arm also carries the old
// and new transport and sample rate. Every item gives exactly one result on
// the output channel (out_valid/out_ready): the mute flag for a callback and
// the guard state, switch description, silence byte and remaining roll counts.
// The result of an item is registered and shown in the cycle after its
// transfer. Items are taken at one per cycle while results drain; the single
// state update path between the input port and the result register sets it.
// in_ready is high whenever the result register is empty or being drained,
// so a stalled receiver holds the result and, one item later, the input.
// Registers must be written (wr_en/wr_index/wr_data) only while idle; the
// block does not enforce it. Index three is ignored. Reset empties the result
// register, stops the guard, loads defaults (rolls zero, lock timeout 4096).
`default_nettype none

module transport_switch_mute_guard_unit
	import tsmg_pkg::*;
#(
	parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [15:0] wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [15:0] frame_count,
	input  wire logic [1:0]  source_transport,
	input  wire logic [1:0]  target_transport,
	input  wire logic [24:0] source_rate,
	input  wire logic [24:0] target_rate,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             mute,
	output logic [2:0]       guard_state,
	output logic [2:0]       switch_kind,
	output logic             rate_changed,
	output logic [7:0]       silence_byte,
	output logic [15:0]      pre_roll_left,
	output logic [15:0]      post_roll_left
);

	// Frame clamp limited to the 16-bit field range
	localparam int unsigned  FRAME_CAP   = (MAX_FRAMES > 65535) ? 65535 : MAX_FRAMES;
	localparam logic [15:0]  FRAME_CAP16 = FRAME_CAP[15:0];

	typedef enum logic [2:0] {
		PH_STOPPED  = GS_STOPPED,
		PH_LOCKING  = GS_LOCKING,
		PH_MUTING   = GS_MUTING,
		PH_READY    = GS_READY,
		PH_FALLBACK = GS_FALLBACK
	} guard_phase_t;

	function automatic logic [15:0] clamp_frames(input logic [15:0] v);
		return (v > FRAME_CAP16) ? FRAME_CAP16 : v;
	endfunction

	function automatic logic [2:0] classify(input logic [1:0] from, input logic [1:0] to,
		input logic rate);
		logic [2:0] k;
		if (from == to)                            k = rate ? SK_RATE : SK_NONE;
		else if (from == TR_PCM && to == TR_DOP)       k = SK_PCM_DOP;
		else if (from == TR_DOP && to == TR_PCM)       k = SK_DOP_PCM;
		else if (from == TR_PCM && to == TR_NATIVE)    k = SK_PCM_NATIVE;
		else if (from == TR_NATIVE && to == TR_PCM)    k = SK_NATIVE_PCM;
		else if (from == TR_DOP && to == TR_NATIVE)    k = SK_DOP_NATIVE;
		else if (from == TR_NATIVE && to == TR_DOP)    k = SK_NATIVE_DOP;
		else                                           k = SK_RATE;
		return k;
	endfunction

	// Configuration registers
	logic [15:0]  pre_roll_cfg_q;
	logic [15:0]  post_roll_cfg_q;
	logic [15:0]  timeout_cfg_q;

	// Guard state
	guard_phase_t phase_q;
	logic [15:0]  pre_q;
	logic [15:0]  post_q;
	logic [16:0]  wait_q;
	logic         lock_seen_q;
	logic         lock_needed_q;
	logic [2:0]   kind_q;
	logic         rate_chg_q;
	logic [1:0]   target_q;
	logic [15:0]  timeout_q;

	// Result register
	logic         out_valid_q;
	logic         mute_q;
	logic [2:0]   state_q;
	logic [2:0]   kind_out_q;
	logic         rate_out_q;
	logic [7:0]   fill_q;
	logic [15:0]  pre_out_q;
	logic [15:0]  post_out_q;

	// Next-state values
	guard_phase_t n_phase;
	logic [15:0]  n_pre;
	logic [15:0]  n_post;
	logic [16:0]  n_wait;
	logic         n_lock_seen;
	logic         n_lock_needed;
	logic [2:0]   n_kind;
	logic         n_rate_chg;
	logic [1:0]   n_target;
	logic [15:0]  n_timeout;
	logic         n_mute;
	logic [7:0]   n_fill;
	logic         enter_mute;
	logic [17:0]  wait_sum;
	logic [15:0]  take_pre;
	logic [15:0]  take_post;
	logic         accept;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign wait_sum  = {1'b0, wait_q} + {2'b00, clamp_frames(frame_count)};
	assign take_pre  = (frame_count < pre_q) ? frame_count : pre_q;
	assign take_post = (frame_count < post_q) ? frame_count : post_q;

	// Update guard state for one item
	always_comb begin
		n_phase       = phase_q;
		n_pre         = pre_q;
		n_post        = post_q;
		n_wait        = wait_q;
		n_lock_seen   = lock_seen_q;
		n_lock_needed = lock_needed_q;
		n_kind        = kind_q;
		n_rate_chg    = rate_chg_q;
		n_target      = target_q;
		n_timeout     = timeout_q;
		n_mute        = 1'b0;
		enter_mute    = 1'b0;
		unique case (mode)
			MODE_CALLBACK: begin
				if (phase_q == PH_FALLBACK) begin
					n_mute = 1'b1;
				end else if (phase_q == PH_LOCKING || phase_q == PH_MUTING) begin
					n_mute = 1'b1;
					if (pre_q != 16'd0) begin
						n_pre = pre_q - take_pre;
					end else begin
						enter_mute = (phase_q == PH_MUTING);
						if (phase_q == PH_LOCKING) begin
							if (lock_seen_q || !lock_needed_q) begin
								if (post_q != 16'd0) begin
									enter_mute = 1'b1;
								end else begin
									n_phase = PH_READY;
									n_mute  = 1'b0;
								end
							end else begin
								// accumulate the wait, saturating
								n_wait = wait_sum[17] ? WAIT_MAX : wait_sum[16:0];
								if (n_wait >= {1'b0, timeout_q}) begin
									n_post  = 16'd0;
									n_phase = PH_FALLBACK;
								end
							end
						end
						// consume post-roll
						if (enter_mute) begin
							n_phase = PH_MUTING;
							if (frame_count != 16'd0) begin
								n_post = post_q - take_post;
								if (n_post == 16'd0) n_phase = PH_READY;
							end
						end
					end
				end
			end
			MODE_ARM: begin
				n_rate_chg    = (source_rate != 25'd0) && (target_rate != 25'd0)
					&& (source_rate != target_rate);
				n_kind        = classify(source_transport, target_transport, n_rate_chg);
				n_target      = target_transport;
				n_timeout     = timeout_cfg_q;
				n_pre         = pre_roll_cfg_q;
				n_post        = post_roll_cfg_q;
				n_wait        = 17'd0;
				n_lock_seen   = 1'b0;
				n_lock_needed = (target_transport != TR_PCM);
				n_phase       = PH_LOCKING;
			end
			MODE_LOCK: begin
				n_lock_seen = 1'b1;
			end
			MODE_STOP: begin
				n_pre   = 16'd0;
				n_post  = 16'd0;
				n_wait  = 17'd0;
				n_phase = PH_STOPPED;
			end
			default: begin
				n_phase = phase_q;
			end
		endcase
		case (n_target)
			TR_PCM:  n_fill = FILL_PCM;
			TR_DOP:  n_fill = FILL_DOP;
			default: n_fill = FILL_NATIVE;
		endcase
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_roll_cfg_q  <= 16'd0;
			post_roll_cfg_q <= 16'd0;
			timeout_cfg_q   <= TIMEOUT_DEFAULT;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PRE_ROLL:  pre_roll_cfg_q  <= clamp_frames(wr_data);
				REG_POST_ROLL: post_roll_cfg_q <= clamp_frames(wr_data);
				REG_TIMEOUT:   timeout_cfg_q   <= (wr_data == 16'd0) ? TIMEOUT_DEFAULT
					: clamp_frames(wr_data);
				default:       pre_roll_cfg_q  <= pre_roll_cfg_q;
			endcase
		end
	end

	// Advance guard state on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_STOPPED;
			pre_q         <= 16'd0;
			post_q        <= 16'd0;
			wait_q        <= 17'd0;
			lock_seen_q   <= 1'b0;
			lock_needed_q <= 1'b0;
			kind_q        <= SK_NONE;
			rate_chg_q    <= 1'b0;
			target_q      <= TR_PCM;
			timeout_q     <= TIMEOUT_DEFAULT;
		end else if (accept) begin
			phase_q       <= n_phase;
			pre_q         <= n_pre;
			post_q        <= n_post;
			wait_q        <= n_wait;
			lock_seen_q   <= n_lock_seen;
			lock_needed_q <= n_lock_needed;
			kind_q        <= n_kind;
			rate_chg_q    <= n_rate_chg;
			target_q      <= n_target;
			timeout_q     <= n_timeout;
		end
	end

	// Track result register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mute_q     <= n_mute;
			state_q    <= n_phase;
			kind_out_q <= n_kind;
			rate_out_q <= n_rate_chg;
			fill_q     <= n_fill;
			pre_out_q  <= n_pre;
			post_out_q <= n_post;
		end
	end

	assign out_valid      = out_valid_q;
	assign mute           = mute_q;
	assign guard_state    = state_q;
	assign switch_kind    = kind_out_q;
	assign rate_changed   = rate_out_q;
	assign silence_byte   = fill_q;
	assign pre_roll_left  = pre_out_q;
	assign post_roll_left = post_out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tsmg_checker.sv =====
// Port-level checker of the transport switch mute guard and its bind.
`default_nettype none
`include "transport_switch_mute_guard_unit_assert.svh"

module tsmg_checker
	import tsmg_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        mute,
	input wire logic [2:0]  guard_state,
	input wire logic [2:0]  switch_kind,
	input wire logic        rate_changed,
	input wire logic [7:0]  silence_byte,
	input wire logic [15:0] pre_roll_left,
	input wire logic [15:0] post_roll_left
);

	// A stalled result holds
	`TSMG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(mute) && $stable(guard_state) && $stable(pre_roll_left)
		&& $stable(post_roll_left) && $stable(silence_byte) && $stable(switch_kind)
		&& $stable(rate_changed))

	// An empty result register never blocks the input
	`TSMG_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)

	// Ready and fallback leave no roll frames pending
	`TSMG_ASSERT_NOW(a_rolls_done, clk, arst_n,
		out_valid && (guard_state == GS_READY || guard_state == GS_FALLBACK),
		pre_roll_left == 16'd0 && post_roll_left == 16'd0)

	// A stopped guard never mutes
	`TSMG_ASSERT_NOW(a_stopped_unmuted, clk, arst_n,
		out_valid && guard_state == GS_STOPPED, !mute)

	// Fill byte is one of the silence fill bytes
	`TSMG_ASSERT_NOW(a_fill_code, clk, arst_n, out_valid,
		silence_byte == FILL_PCM || silence_byte == FILL_DOP || silence_byte == FILL_NATIVE)

endmodule

bind transport_switch_mute_guard_unit tsmg_checker u_tsmg_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench of the transport switch mute guard with directed and random items.
`timescale 1ns / 1ps

module testbench;
	import tsmg_pkg::*;

	// Transport code with no name of its own; the guard gives it the DSD fill byte and lock wait
	localparam logic [1:0] TR_RESERVED = 2'd3;
	// Register index that the block ignores
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int RANDOM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 100;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] frames;
		logic [1:0]  from_tr;
		logic [1:0]  to_tr;
		logic [24:0] from_rate;
		logic [24:0] to_rate;
	} guard_item_t;

	typedef struct packed {
		logic        mute;
		logic [2:0]  state;
		logic [2:0]  kind;
		logic        rate_chg;
		logic [7:0]  fill;
		logic [15:0] pre_left;
		logic [15:0] post_left;
	} guard_result_t;

	typedef enum {DRAIN_FREE, DRAIN_LIGHT, DRAIN_HEAVY, DRAIN_TOGGLE} drain_style_t;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [15:0] wr_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  mode;
	logic [15:0] frame_count;
	logic [1:0]  source_transport;
	logic [1:0]  target_transport;
	logic [24:0] source_rate;
	logic [24:0] target_rate;
	logic        out_valid;
	logic        out_ready;
	logic        mute;
	logic [2:0]  guard_state;
	logic [2:0]  switch_kind;
	logic        rate_changed;
	logic [7:0]  silence_byte;
	logic [15:0] pre_roll_left;
	logic [15:0] post_roll_left;

	// Predictor copy of registers and guard state
	logic [15:0] cfg_pre;
	logic [15:0] cfg_post;
	logic [15:0] cfg_timeout;
	logic [2:0]  guard_phase;
	logic [15:0] pre_count;
	logic [15:0] post_count;
	logic [16:0] wait_count;
	logic        lock_seen;
	logic        lock_needed;
	logic [2:0]  held_kind;
	logic        held_rate_chg;
	logic [1:0]  held_target;
	logic [15:0] held_timeout;

	guard_result_t guard_expect_q[$];
	guard_result_t want;
	guard_result_t got;

	int items_sent;
	int results_checked;
	int mismatch_count;
	int orphan_count;
	int settings_used;
	int ready_hits;
	int fallback_hits;
	int burst_left;
	bit sender_gaps;

	transport_switch_mute_guard_unit i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.frame_count      (frame_count),
		.source_transport (source_transport),
		.target_transport (target_transport),
		.source_rate      (source_rate),
		.target_rate      (target_rate),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.mute             (mute),
		.guard_state      (guard_state),
		.switch_kind      (switch_kind),
		.rate_changed     (rate_changed),
		.silence_byte     (silence_byte),
		.pre_roll_left    (pre_roll_left),
		.post_roll_left   (post_roll_left)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Advance the guard by one item and return the result it shows
	function automatic guard_result_t guard_predict(input guard_item_t it);
		guard_result_t r;
		logic          muted;
		logic [17:0]   wait_sum;
		muted = 1'b0;
		case (it.mode)
		MODE_CALLBACK: begin
			if (guard_phase == GS_FALLBACK) begin
				muted = 1'b1;
			end else if (guard_phase == GS_STOPPED || guard_phase == GS_READY) begin
				muted = 1'b0;
			end else if (pre_count != 16'd0) begin
				// consume pre-roll first
				pre_count = (it.frames < pre_count) ? pre_count - it.frames : 16'd0;
				muted = 1'b1;
			end else if (guard_phase == GS_LOCKING && lock_needed && !lock_seen) begin
				// wait for lock; frames fit MAX_FRAMES already, the sum saturates
				wait_sum = {1'b0, wait_count} + {2'b00, it.frames};
				wait_count = (wait_sum > {1'b0, WAIT_MAX}) ? WAIT_MAX : wait_sum[16:0];
				if (wait_count >= {1'b0, held_timeout}) begin
					pre_count = 16'd0;
					post_count = 16'd0;
					guard_phase = GS_FALLBACK;
				end
				muted = 1'b1;
			end else begin
				if (guard_phase == GS_LOCKING)
					guard_phase = (post_count != 16'd0) ? GS_MUTING : GS_READY;
				if (guard_phase == GS_MUTING) begin
					muted = 1'b1;
					if (it.frames != 16'd0) begin
						if (post_count != 16'd0) begin
							post_count = (it.frames < post_count) ?
								post_count - it.frames : 16'd0;
							if (post_count == 16'd0)
								guard_phase = GS_READY;
						end else begin
							guard_phase = GS_READY;
						end
					end
				end
			end
		end
		MODE_ARM: begin
			held_rate_chg = it.from_rate != 25'd0 && it.to_rate != 25'd0 &&
				it.from_rate != it.to_rate;
			if (it.from_tr == it.to_tr) begin
				held_kind = held_rate_chg ? SK_RATE : SK_NONE;
			end else begin
				case ({it.from_tr, it.to_tr})
				{TR_PCM, TR_DOP}:       held_kind = SK_PCM_DOP;
				{TR_DOP, TR_PCM}:       held_kind = SK_DOP_PCM;
				{TR_PCM, TR_NATIVE}:    held_kind = SK_PCM_NATIVE;
				{TR_NATIVE, TR_PCM}:    held_kind = SK_NATIVE_PCM;
				{TR_DOP, TR_NATIVE}:    held_kind = SK_DOP_NATIVE;
				{TR_NATIVE, TR_DOP}:    held_kind = SK_NATIVE_DOP;
				default:                held_kind = SK_RATE;
				endcase
			end
			held_target = it.to_tr;
			held_timeout = cfg_timeout;
			pre_count = cfg_pre;
			post_count = cfg_post;
			wait_count = 17'd0;
			lock_seen = 1'b0;
			lock_needed = it.to_tr != TR_PCM;
			guard_phase = GS_LOCKING;
		end
		MODE_LOCK: begin
			lock_seen = 1'b1;
		end
		default: begin
			pre_count = 16'd0;
			post_count = 16'd0;
			wait_count = 17'd0;
			guard_phase = GS_STOPPED;
		end
		endcase
		r.mute = muted;
		r.state = guard_phase;
		r.kind = held_kind;
		r.rate_chg = held_rate_chg;
		r.fill = (held_target == TR_PCM) ? FILL_PCM :
			((held_target == TR_DOP) ? FILL_DOP : FILL_NATIVE);
		r.pre_left = pre_count;
		r.post_left = post_count;
		return r;
	endfunction

	function automatic guard_item_t guard_item(input logic [1:0] md, input logic [15:0] frames,
			input logic [1:0] from_tr, input logic [1:0] to_tr,
			input logic [24:0] from_rate, input logic [24:0] to_rate);
		guard_item_t it;
		it.mode = md;
		it.frames = frames;
		it.from_tr = from_tr;
		it.to_tr = to_tr;
		it.from_rate = from_rate;
		it.to_rate = to_rate;
		return it;
	endfunction

	// Item with random content in the fields that only arm reads
	function automatic guard_item_t noisy_item(input logic [1:0] md, input logic [15:0] frames);
		return guard_item(md, frames, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
			25'($urandom_range(0, 33554431)), 25'($urandom_range(0, 33554431)));
	endfunction

	function automatic logic [15:0] pick_frames();
		case ($urandom_range(0, 9))
		0:       return 16'd0;
		1:       return 16'hFFFF;
		2, 3:    return 16'($urandom_range(0, 65535));
		4, 5:    return 16'($urandom_range(1, 600));
		default: return 16'($urandom_range(1, 40));
		endcase
	endfunction

	function automatic logic [15:0] pick_roll();
		case ($urandom_range(0, 7))
		0:       return 16'd0;
		1:       return 16'hFFFF;
		2:       return 16'($urandom_range(0, 65535));
		3, 4:    return 16'($urandom_range(1, 400));
		default: return 16'($urandom_range(1, 40));
		endcase
	endfunction

	function automatic logic [15:0] pick_timeout();
		case ($urandom_range(0, 7))
		0:       return 16'd0;
		1:       return 16'd1;
		2:       return 16'hFFFF;
		3:       return 16'($urandom_range(0, 65535));
		4, 5:    return 16'($urandom_range(1, 4096));
		default: return 16'($urandom_range(1, 200));
		endcase
	endfunction

	// Send one item in the current burst, open a gap between bursts when sender gaps are on
	task automatic push_guard_item(input guard_item_t it);
		int gap;
		guard_result_t r;
		if (burst_left == 0) begin
			gap = sender_gaps ? $urandom_range(1, 8) : 0;
			burst_left = $urandom_range(1, 16);
			if (gap != 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		mode <= it.mode;
		frame_count <= it.frames;
		source_transport <= it.from_tr;
		target_transport <= it.to_tr;
		source_rate <= it.from_rate;
		target_rate <= it.to_rate;
		do @(posedge clk); while (!in_ready);
		r = guard_predict(it);
		guard_expect_q.push_back(r);
		items_sent++;
		if (r.state == GS_READY)
			ready_hits++;
		if (r.state == GS_FALLBACK)
			fallback_hits++;
	endtask

	// Drop valid and wait until every result has drained
	task automatic settle_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (guard_expect_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
		REG_PRE_ROLL:  cfg_pre = val;
		REG_POST_ROLL: cfg_post = val;
		REG_TIMEOUT:   cfg_timeout = (val == 16'd0) ? TIMEOUT_DEFAULT : val;
		default:       ;
		endcase
	endtask

	// Load all three registers while idle, plus a write the block must ignore
	task automatic set_guard_regs(input logic [15:0] pre, input logic [15:0] post,
			input logic [15:0] timeout);
		settle_idle();
		write_reg(REG_PRE_ROLL, pre);
		write_reg(REG_POST_ROLL, post);
		write_reg(REG_TIMEOUT, timeout);
		write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
		settings_used++;
	endtask

	// Callbacks, lock and stop while stopped after reset
	task automatic test_idle_guard();
		push_guard_item(guard_item(MODE_CALLBACK, 16'd0, TR_PCM, TR_PCM, 25'd0, 25'd0));
		push_guard_item(guard_item(MODE_CALLBACK, 16'hFFFF, TR_PCM, TR_PCM, 25'd0, 25'd0));
		push_guard_item(guard_item(MODE_LOCK, 16'd0, TR_PCM, TR_PCM, 25'd0, 25'd0));
		push_guard_item(guard_item(MODE_STOP, 16'd0, TR_PCM, TR_PCM, 25'd0, 25'd0));
	endtask

	// PCM target: pre-roll, no lock wait, post-roll, ready
	task automatic test_pcm_rolls();
		set_guard_regs(16'd3, 16'd2, 16'd0);
		push_guard_item(guard_item(MODE_ARM, 16'd0, TR_PCM, TR_PCM, 25'd48000, 25'd48000));
		push_guard_item(guard_item(MODE_CALLBACK, 16'd2, TR_PCM, TR_PCM, 25'd0, 25'd0));
		push_guard_item(guard_item(MODE_CALLBACK, 16'd0, TR_PCM, TR_PCM, 25'd0, 25'd0));
		push_guard_item(guard_item(MODE_CALLBACK, 16'd5, TR_PCM, TR_PCM, 25'd0, 25'd0));
		push_guard_item(guard_item(MODE_CALLBACK, 16'd1, TR_PCM, TR_PCM, 25'd0, 25'd0));
		push_guard_item(guard_item(MODE_CALLBACK, 16'hFFFF, TR_PCM, TR_PCM, 25'd0, 25'd0));
		push_guard_item(guard_item(MODE_CALLBACK, 16'd7, TR_PCM, TR_PCM, 25'd0, 25'd0));
	endtask

	// DSD target: zero-frame wait, confirm lock, post-roll, stop keeps the description
	task automatic test_dsd_lock();
		set_guard_regs(16'd0, 16'd4, 16'd100);
		push_guard_item(guard_item(MODE_ARM, 16'd0, TR_PCM, TR_NATIVE, 25'd0, 25'd96000));
		push_guard_item(guard_item(MODE_CALLBACK, 16'd0, TR_PCM, TR_PCM, 25'd0, 25'd0));
		push_guard_item(guard_item(MODE_CALLBACK, 16'd40, TR_PCM, TR_PCM, 25'd0, 25'd0));
		push_guard_item(guard_item(MODE_LOCK, 16'd0, TR_PCM, TR_PCM, 25'd0, 25'd0));
		push_guard_item(guard_item(MODE_CALLBACK, 16'd3, TR_PCM, TR_PCM, 25'd0, 25'd0));
		push_guard_item(guard_item(MODE_STOP, 16'd0, TR_PCM, TR_PCM, 25'd0, 25'd0));
	endtask

	// Timeout at its maximum, fallback, and the unnamed transport code
	task automatic test_fallback();
		set_guard_regs(16'd1, 16'd5, 16'hFFFF);
		push_guard_item(guard_item(MODE_ARM, 16'd0, TR_DOP, TR_NATIVE, 25'd44100, 25'd88200));
		push_guard_item(guard_item(MODE_CALLBACK, 16'hFFFF, TR_PCM, TR_PCM, 25'd0, 25'd0));
		push_guard_item(guard_item(MODE_CALLBACK, 16'hFFFF, TR_PCM, TR_PCM, 25'd0, 25'd0));
		push_guard_item(guard_item(MODE_CALLBACK, 16'd0, TR_PCM, TR_PCM, 25'd0, 25'd0));
		push_guard_item(guard_item(MODE_ARM, 16'd0, TR_RESERVED, TR_PCM,
			25'h1FFFFFF, 25'h1FFFFFF));
		push_guard_item(guard_item(MODE_ARM, 16'd0, TR_PCM, TR_RESERVED,
			25'h1FFFFFF, 25'd1));
		push_guard_item(guard_item(MODE_CALLBACK, 16'd1, TR_PCM, TR_PCM, 25'd0, 25'd0));
	endtask

	// Arm/callback sequences with random content over several register settings
	task automatic test_random_switches();
		int phase;
		int start_count;
		int n_cb;
		int lock_at;
		logic [24:0] rate_a;
		logic [24:0] rate_b;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
			0:       set_guard_regs(16'd0, 16'd0, 16'd0);
			1:       set_guard_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
			default: set_guard_regs(pick_roll(), pick_roll(), pick_timeout());
			endcase
			// no sender gaps in one phase
			sender_gaps = (phase != 2);
			start_count = items_sent;
			while (items_sent - start_count < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 9) == 0) begin
					push_guard_item(noisy_item(2'($urandom_range(0, 3)), pick_frames()));
				end else begin
					rate_a = 25'($urandom_range(1, 33554431));
					case ($urandom_range(0, 3))
					0: begin
						rate_b = $urandom_range(0, 1) ? 25'd0 : rate_a;
						rate_a = $urandom_range(0, 1) ? 25'd0 : rate_a;
					end
					1:       rate_b = rate_a;
					default: rate_b = 25'($urandom_range(1, 33554431));
					endcase
					push_guard_item(guard_item(MODE_ARM, 16'($urandom_range(0, 65535)),
						($urandom_range(0, 7) == 0) ? TR_RESERVED : 2'($urandom_range(0, 2)),
						($urandom_range(0, 7) == 0) ? TR_RESERVED : 2'($urandom_range(0, 2)),
						rate_a, rate_b));
					n_cb = $urandom_range(1, 12);
					lock_at = $urandom_range(0, n_cb + 3);
					for (int i = 0; i < n_cb; i++) begin
						if (i == lock_at)
							push_guard_item(noisy_item(MODE_LOCK,
								16'($urandom_range(0, 65535))));
						push_guard_item(noisy_item(MODE_CALLBACK, pick_frames()));
					end
					if ($urandom_range(0, 5) == 0)
						push_guard_item(noisy_item(MODE_STOP,
							16'($urandom_range(0, 65535))));
				end
			end
		end
		sender_gaps = 1'b1;
	endtask

	// Receiver stalls in stretches of changing style
	initial begin : drain_side
		drain_style_t style;
		int span;
		out_ready = 1'b0;
		forever begin
			style = drain_style_t'($urandom_range(0, 3));
			span = $urandom_range(10, 80);
			repeat (span) begin
				@(negedge clk);
				case (style)
				DRAIN_FREE:  out_ready <= 1'b1;
				DRAIN_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
				DRAIN_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
				default:     out_ready <= ~out_ready;
				endcase
			end
		end
	end

	// Check each result transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got = {mute, guard_state, switch_kind, rate_changed, silence_byte,
				pre_roll_left, post_roll_left};
			if (guard_expect_q.size() == 0) begin
				orphan_count++;
				if (mismatch_count + orphan_count <= 10)
					$display("%0t: result with nothing expected: state %0d mute %0b",
						$realtime, got.state, got.mute);
			end else begin
				want = guard_expect_q.pop_front();
				results_checked++;
				if (got.mute !== want.mute || got.state !== want.state ||
						got.kind !== want.kind || got.rate_chg !== want.rate_chg ||
						got.fill !== want.fill || got.pre_left !== want.pre_left ||
						got.post_left !== want.post_left) begin
					mismatch_count++;
					if (mismatch_count + orphan_count <= 10)
						$display({"%0t: result %0d mute/state/kind/rate/fill/pre/post ",
							"expected %0b/%0d/%0d/%0b/%h/%0d/%0d got %0b/%0d/%0d/%0b/%h/%0d/%0d"},
							$realtime, results_checked,
							want.mute, want.state, want.kind, want.rate_chg, want.fill,
							want.pre_left, want.post_left,
							got.mute, got.state, got.kind, got.rate_chg, got.fill,
							got.pre_left, got.post_left);
				end
			end
		end
	end

	initial begin : run_limit
		#2_000_000;
		$display("Run stopped at the time limit with %0d results outstanding.",
			guard_expect_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		int failures;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_PRE_ROLL;
		wr_data = 16'd0;
		in_valid = 1'b0;
		mode = MODE_CALLBACK;
		frame_count = 16'd0;
		source_transport = TR_PCM;
		target_transport = TR_PCM;
		source_rate = 25'd0;
		target_rate = 25'd0;
		// predictor starts from the reset state
		cfg_pre = 16'd0;
		cfg_post = 16'd0;
		cfg_timeout = TIMEOUT_DEFAULT;
		guard_phase = GS_STOPPED;
		pre_count = 16'd0;
		post_count = 16'd0;
		wait_count = 17'd0;
		lock_seen = 1'b0;
		lock_needed = 1'b0;
		held_kind = SK_NONE;
		held_rate_chg = 1'b0;
		held_target = TR_PCM;
		held_timeout = TIMEOUT_DEFAULT;
		items_sent = 0;
		results_checked = 0;
		mismatch_count = 0;
		orphan_count = 0;
		settings_used = 0;
		ready_hits = 0;
		fallback_hits = 0;
		burst_left = 0;
		sender_gaps = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_idle_guard();
		test_pcm_rolls();
		test_dsd_lock();
		test_fallback();
		test_random_switches();
		settle_idle();

		failures = mismatch_count + orphan_count + guard_expect_q.size();
		$display("Sent %0d items under %0d register settings, checked %0d results.",
			items_sent, settings_used, results_checked);
		$display("Guard reached ready %0d times and fallback %0d times; %0d failures.",
			ready_hits, fallback_hits, failures);
		if (failures == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
